// ===== src/kpsr_pkg.sv =====
// ----------------------------------------------------------------------------
// kpsr_pkg
// Shared sizes, codes and controller/datapath interface types for the
// select-and-remove order-statistic store.
// ----------------------------------------------------------------------------
package kpsr_pkg;

  localparam int CAPACITY   = 1024;
  localparam int LEVELS     = $clog2(CAPACITY);
  localparam int LEAF_BASE  = 1 << LEVELS;
  localparam int TREE_DEPTH = 2 * LEAF_BASE;
  localparam int NODE_W     = LEVELS + 1;
  localparam int SLOT_W     = LEVELS;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int LVL_W      = $clog2(LEVELS + 1);
  localparam int VALUE_W    = 32;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_LOADED  = 2'd0,
    ST_REMOVED = 2'd1,
    ST_RANGE   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic accept;
    logic first;
    logic step;
    logic last;
    logic emit;
  } kpsr_cmd_t;

  typedef struct packed {
    logic reject;
    logic out_busy;
  } kpsr_sts_t;

endpackage

// ===== src/kpsr_ram.sv =====
// ----------------------------------------------------------------------------
// kpsr_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kpsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/kpsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// kpsr_ctrl
// Sequencer: accepts a word, walks the count tree one level per cycle (a
// rejected word skips the walk) and hands the result to the output register.
// ----------------------------------------------------------------------------
module kpsr_ctrl
  import kpsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  kpsr_sts_t sts,
  output kpsr_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [LVL_W-1:0] lvl, lvl_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.accept = in_ready & in_valid;
    cmd.first  = (state == S_WALK) && (lvl == '0);
    cmd.step   = (state == S_WALK) && (lvl != '0);
    cmd.last   = (state == S_WALK) && (lvl == LVL_W'(LEVELS));
    cmd.emit   = (state == S_EMIT) && !sts.out_busy;
  end

  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    case (state)
      S_IDLE: begin
        lvl_next = '0;
        if (cmd.accept) begin
          state_next = sts.reject ? S_EMIT : S_WALK;
        end
      end
      S_WALK: begin
        lvl_next = lvl + LVL_W'(1);
        if (cmd.last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cmd.emit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        lvl_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl   <= '0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
    end
  end

endmodule

// ===== src/kpsr_dp.sv =====
// ----------------------------------------------------------------------------
// kpsr_dp
// Datapath: value store, count tree RAM, fill and present counters, the
// per-level descent step and the output register.
// ----------------------------------------------------------------------------
module kpsr_dp
  import kpsr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  kpsr_cmd_t                 cmd,
  output kpsr_sts_t                 sts,
  input  logic                      opcode,
  input  logic signed [VALUE_W-1:0] load_value,
  input  logic [CNT_W-1:0]          rank,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [1:0]                status,
  output logic signed [VALUE_W-1:0] removed_value,
  output logic [SLOT_W-1:0]         removed_slot
);

  logic [CNT_W-1:0]   loaded_count;
  logic [CNT_W-1:0]   present_count;
  logic               is_load;
  status_t            res_status;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   cur_cnt;
  logic [NODE_W-1:0]  rd_addr;
  logic [SLOT_W-1:0]  rd_start;
  logic [SLOT_W-1:0]  rd_span;
  logic [SLOT_W-1:0]  slot;

  logic [CNT_W-1:0]   tree_rdata;
  logic [VALUE_W-1:0] vram_rdata;

  logic               full;
  logic               rank_bad;
  logic [CNT_W-1:0]   left_cnt;
  logic               go_left;
  logic [NODE_W-1:0]  ch_addr;
  logic [SLOT_W-1:0]  ch_start;
  logic [NODE_W-1:0]  ch_span;
  logic [CNT_W-1:0]   ch_cnt;
  logic [CNT_W-1:0]   ch_rem;
  logic [CNT_W-1:0]   wr_cnt;
  logic [SLOT_W-1:0]  half;
  logic               dir;
  logic [NODE_W-1:0]  nxt_addr;
  logic [SLOT_W-1:0]  nxt_start;
  logic               vram_we;

  assign full     = (loaded_count == CNT_W'(CAPACITY));
  assign rank_bad = (rank == '0) || (rank > present_count);

  assign sts.reject   = (opcode == OP_LOAD) ? full : rank_bad;
  assign sts.out_busy = out_valid & ~out_ready;

  always_comb begin
    // nodes whose leftmost leaf was never loaded have never been written
    left_cnt = (CNT_W'(rd_start) >= loaded_count) ? '0 : tree_rdata;
    go_left  = (left_cnt >= rem);

    ch_span = cmd.first ? NODE_W'(LEAF_BASE) : NODE_W'(rd_span);
    if (cmd.first) begin
      ch_addr  = NODE_W'(1);
      ch_start = '0;
      ch_cnt   = present_count;
      ch_rem   = rem;
    end else if (is_load) begin
      ch_addr  = rd_addr;
      ch_start = rd_start;
      ch_cnt   = left_cnt + CNT_W'(1);
      ch_rem   = rem;
    end else if (go_left) begin
      ch_addr  = rd_addr;
      ch_start = rd_start;
      ch_cnt   = left_cnt;
      ch_rem   = rem;
    end else begin
      ch_addr  = rd_addr | NODE_W'(1);
      ch_start = rd_start | rd_span;
      ch_cnt   = cur_cnt - left_cnt;
      ch_rem   = rem - left_cnt;
    end

    wr_cnt = is_load ? ch_cnt : ch_cnt - CNT_W'(1);

    // load follows the path of the next free leaf; remove reads the left child
    half      = SLOT_W'(ch_span >> 1);
    dir       = is_load & (|(loaded_count[SLOT_W-1:0] & half));
    nxt_addr  = {ch_addr[NODE_W-2:0], dir};
    nxt_start = ch_start | (dir ? half : '0);
  end

  assign vram_we = cmd.accept && (opcode == OP_LOAD) && !full;

  kpsr_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TREE_DEPTH)
  ) u_tree (
    .clk   (clk),
    .we    (cmd.step),
    .waddr (ch_addr),
    .wdata (wr_cnt),
    .re    (cmd.first | (cmd.step & ~cmd.last)),
    .raddr (nxt_addr),
    .rdata (tree_rdata)
  );

  kpsr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_values (
    .clk   (clk),
    .we    (vram_we),
    .waddr (loaded_count[SLOT_W-1:0]),
    .wdata (load_value),
    .re    (cmd.last & ~is_load),
    .raddr (ch_start),
    .rdata (vram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count  <= '0;
      present_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.last) begin
        if (is_load) begin
          loaded_count  <= loaded_count + CNT_W'(1);
          present_count <= present_count + CNT_W'(1);
        end else begin
          present_count <= present_count - CNT_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_load <= (opcode == OP_LOAD);
      rem     <= rank;
      if (opcode == OP_LOAD) begin
        res_status <= full ? ST_FULL : ST_LOADED;
      end else begin
        res_status <= rank_bad ? ST_RANGE : ST_REMOVED;
      end
    end
    if (cmd.first | cmd.step) begin
      rd_addr  <= nxt_addr;
      rd_start <= nxt_start;
      rd_span  <= half;
      cur_cnt  <= ch_cnt;
      rem      <= ch_rem;
    end
    if (cmd.last) begin
      slot <= ch_start;
    end
    if (cmd.emit) begin
      status <= res_status;
      if (res_status == ST_REMOVED) begin
        removed_value <= vram_rdata;
        removed_slot  <= slot;
      end else begin
        removed_value <= '0;
        removed_slot  <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_present_le_loaded: assert property (@(posedge clk) disable iff (rst)
    present_count <= loaded_count)
    else $error("present count exceeds loaded count");

  a_loaded_le_cap: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CNT_W'(CAPACITY))
    else $error("loaded count exceeds capacity");

  a_left_le_parent: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !is_load) |-> (left_cnt <= cur_cnt))
    else $error("left child count exceeds parent count");

  a_leaf_present: assert property (@(posedge clk) disable iff (rst)
    (cmd.last && !is_load) |-> (ch_cnt == CNT_W'(1)))
    else $error("descent ended on an absent leaf");
`endif

endmodule

// ===== src/kth_present_select_remove_unit.sv =====
// ----------------------------------------------------------------------------
// kth_present_select_remove_unit
// Order-statistic store: appends values and removes the rank-th present one,
// using a binary count tree over the slots.
// ----------------------------------------------------------------------------
//   channel | signals                                 | handshake
//   --------+-----------------------------------------+---------------------
//   in      | opcode, load_value, rank                | in_valid / in_ready
//   out     | status, removed_value, removed_slot     | out_valid / out_ready
//
// A load or an in-range remove walks the count tree from the root to a leaf,
// each level paced by the registered read of the count RAM, and then goes to
// the result register. A rejected word skips the walk. One word is in work at
// a time; the next is taken while a result waits.
// After reset the tree reads as all zero at once: nodes beyond the fill
// count are masked, so there is no clearing pass.
// An output stall holds the finished result; no new word is taken while it blocks the next result.
// ----------------------------------------------------------------------------
module kth_present_select_remove_unit
  import kpsr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      opcode,
  input  logic signed [VALUE_W-1:0] load_value,
  input  logic [CNT_W-1:0]          rank,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic signed [VALUE_W-1:0] removed_value,
  output logic [SLOT_W-1:0]         removed_slot
);

  kpsr_cmd_t cmd;
  kpsr_sts_t sts;

  kpsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kpsr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (opcode),
    .load_value    (load_value),
    .rank          (rank),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .status        (status),
    .removed_value (removed_value),
    .removed_slot  (removed_slot)
  );

endmodule
